[design/rsch_pkg.sv]
package rsch_pkg;

  localparam int NUM_SPHERES = 8;
  localparam int FRAC_BITS   = 16;

  // slot index and comparison tree sizes
  localparam int IDX_W    = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;
  localparam int TREE_LVL = IDX_W;
  localparam int NUM_LEAF = 1 << TREE_LVL;

  // one result bit per square root stage
  localparam int SQRT_STEPS = 32;
  // lane stages: difference, products, sums, s, s squared, radicand, roots, candidates
  localparam int LANE_LAT = 6 + SQRT_STEPS + 1;
  localparam int BEST_STG = LANE_LAT + 1 + TREE_LVL;
  localparam int MUL_STG  = BEST_STG + 1;

  localparam int S_TDATA_W = 256;
  localparam int M_TDATA_W = 136;
  localparam int T_W       = 34;

  localparam logic [1:0] CFG_RADIUS_SQ = 2'd0;
  localparam logic [1:0] CFG_MIN_DIST  = 2'd1;
  localparam logic [1:0] CFG_ACTIVE    = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[design/rsch_lane.sv]
module rsch_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] cz,
  input  logic signed [31:0] ox,
  input  logic signed [31:0] oy,
  input  logic signed [31:0] oz,
  input  logic signed [17:0] dx,
  input  logic signed [17:0] dy,
  input  logic signed [17:0] dz,
  input  logic        [30:0] radius_sq,
  output logic signed [rsch_pkg::T_W-1:0] near_t,
  output logic signed [rsch_pkg::T_W-1:0] far_t,
  output logic               ok
);

  localparam int N = rsch_pkg::SQRT_STEPS;

  typedef struct packed {
    logic [62:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // one digit of a floor square root: try root bit b against the remainder
  function automatic sqrt_t sqrt_step(input logic [62:0] rem, input logic [31:0] root,
                                      input int b);
    logic [64:0] trial;
    sqrt_t r;
    trial = (65'(root) << (b + 1)) | (65'(1) << (2 * b));
    r.rem = rem;
    r.root = root;
    if (65'(rem) >= trial) begin
      r.rem = rem - trial[62:0];
      r.root = root | (32'(1) << b);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_sym(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) r = 32'sh7fffffff;
    else if (v < -52'sd2147483647) r = -32'sh7fffffff;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] cen[3];
  logic signed [31:0] org[3];
  logic signed [17:0] dir[3];
  logic        [63:0] r2s;

  assign cen[0] = cx;
  assign cen[1] = cy;
  assign cen[2] = cz;
  assign org[0] = ox;
  assign org[1] = oy;
  assign org[2] = oz;
  assign dir[0] = dx;
  assign dir[1] = dy;
  assign dir[2] = dz;
  assign r2s = 64'(radius_sq) << rsch_pkg::FRAC_BITS;

  logic signed [31:0] l_q[3];
  logic signed [17:0] d_q[3];
  logic signed [49:0] ld_q[3];
  logic        [62:0] ll_q[3];
  logic signed [51:0] dot_q;
  logic        [63:0] lsq3_q;
  logic signed [31:0] s4_q;
  logic        [63:0] lsq4_q;
  logic signed [31:0] s5_q;
  logic        [61:0] s2_q;
  logic        [63:0] lsq5_q;
  logic               early_q;
  logic        [62:0] rem_q[N+1];
  logic        [31:0] root_q[N+1];
  logic signed [31:0] s_q[N+1];
  logic               ok_q[N+1];

  logic signed [63:0] sq_full[3];
  logic signed [63:0] s2_full;
  logic signed [65:0] rad;
  sqrt_t              step[N];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = 64'(l_q[i]) * 64'(l_q[i]);
    end
    s2_full = 64'(s4_q) * 64'(s4_q);
    rad = $signed(66'(r2s)) + $signed(66'(s2_q)) - $signed(66'(lsq5_q));
    for (int k = 0; k < N; k++) begin
      step[k] = sqrt_step(rem_q[k], root_q[k], N - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l_q[i] <= rsch_pkg::sat32(64'(cen[i]) - 64'(org[i]));
        d_q[i] <= dir[i];
        ld_q[i] <= 50'(l_q[i]) * 50'(d_q[i]);
        ll_q[i] <= sq_full[i][62:0];
      end
      dot_q <= 52'(ld_q[0]) + 52'(ld_q[1]) + 52'(ld_q[2]);
      lsq3_q <= 64'(ll_q[0]) + 64'(ll_q[1]) + 64'(ll_q[2]);
      s4_q <= sat_sym(dot_q >>> rsch_pkg::FRAC_BITS);
      lsq4_q <= lsq3_q;
      s5_q <= s4_q;
      s2_q <= s2_full[61:0];
      lsq5_q <= lsq4_q;
      early_q <= s4_q[31] && (lsq4_q > r2s);
      // negative radicand means the ray passes outside the sphere
      rem_q[0] <= rad[62:0];
      root_q[0] <= '0;
      s_q[0] <= s5_q;
      ok_q[0] <= !early_q && !rad[65];
      for (int k = 0; k < N; k++) begin
        rem_q[k+1] <= step[k].rem;
        root_q[k+1] <= step[k].root;
        s_q[k+1] <= s_q[k];
        ok_q[k+1] <= ok_q[k];
      end
      near_t <= 34'(s_q[N]) - $signed(34'(root_q[N]));
      far_t <= 34'(s_q[N]) + $signed(34'(root_q[N]));
      ok <= ok_q[N];
    end
  end

endmodule

[design/ray_sphere_closest_hit.sv]
// An accepted trace item runs through the 32-stage square root in each sphere lane and
// then the comparison tree. Throughput: one item per cycle while the output is not
// stalled; a load item takes a pipeline slot and gives no result.
// Reset: rst (synchronous) clears the valid bits and sets radius_squared to 16384,
// min_distance to 1 and active_spheres to 0. Sphere centers are not reset.
module ray_sphere_closest_hit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // slot, center_x_in, center_y_in, center_z_in, origin_x, origin_y, origin_z,
  // dir_x, dir_y, dir_z
  input  logic [rsch_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // cmd
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sphere_index, distance, point_x, point_y, point_z
  output logic [rsch_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // hit
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int NS = rsch_pkg::NUM_SPHERES;
  localparam int NL = rsch_pkg::NUM_LEAF;
  localparam int TL = rsch_pkg::TREE_LVL;
  localparam int IW = rsch_pkg::IDX_W;
  localparam int TW = rsch_pkg::T_W;
  localparam int MS = rsch_pkg::MUL_STG;
  localparam int BS = rsch_pkg::BEST_STG;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dz;
  } ray_t;

  typedef struct packed {
    logic                 v;
    logic [IW-1:0]        idx;
    logic signed [TW-1:0] t;
  } cand_t;

  // keep a unless b is valid and strictly nearer: ties go to the earlier one
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (b.v && (!a.v || (b.t < a.t))) r = b;
    return r;
  endfunction

  // configuration registers written only while pipeline is empty: user rule, unchecked
  logic [30:0] radius_sq;
  logic [15:0] min_dist;
  logic [3:0]  active;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq <= 31'd16384;
      min_dist <= 16'd1;
      active <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsch_pkg::CFG_RADIUS_SQ: radius_sq <= cfg_data[30:0];
        rsch_pkg::CFG_MIN_DIST:  min_dist <= cfg_data[15:0];
        rsch_pkg::CFG_ACTIVE:    active <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline advances together; hold everything while the output is stalled
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic              in_acc;
  logic [2:0]        in_slot;
  ray_t              in_ray;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_slot = s_axis_tdata[2:0];
  assign in_ray.ox = s_axis_tdata[130:99];
  assign in_ray.oy = s_axis_tdata[162:131];
  assign in_ray.oz = s_axis_tdata[194:163];
  assign in_ray.dx = s_axis_tdata[212:195];
  assign in_ray.dy = s_axis_tdata[230:213];
  assign in_ray.dz = s_axis_tdata[248:231];

  // sphere table: a load writes its slot; lanes read the centers together with the
  // registered ray in ray_q[0], so a later load never reaches an earlier ray
  logic signed [31:0] cen_x[NS];
  logic signed [31:0] cen_y[NS];
  logic signed [31:0] cen_z[NS];

  always_ff @(posedge clk) begin
    if (in_acc && !s_axis_tuser[0] && (32'(in_slot) < 32'(NS))) begin
      cen_x[IW'(in_slot)] <= s_axis_tdata[34:3];
      cen_y[IW'(in_slot)] <= s_axis_tdata[66:35];
      cen_z[IW'(in_slot)] <= s_axis_tdata[98:67];
    end
  end

  // ray delay line: only trace items carry a valid bit, loads drop out here
  ray_t ray_q[MS+1];
  logic vld_q[MS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p <= MS; p++) vld_q[p] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid && s_axis_tuser[0];
      for (int p = 1; p <= MS; p++) vld_q[p] <= vld_q[p-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray_q[0] <= in_ray;
      for (int p = 1; p <= MS; p++) ray_q[p] <= ray_q[p-1];
    end
  end

  // one lane per sphere slot, padded lanes report no hit
  logic signed [TW-1:0] lane_near[NL];
  logic signed [TW-1:0] lane_far[NL];
  logic                 lane_ok[NL];

  for (genvar k = 0; k < NL; k++) begin : g_lane
    if (k < NS) begin : g_real
      rsch_lane u_lane (
        .clk       (clk),
        .en        (en),
        .cx        (cen_x[k]),
        .cy        (cen_y[k]),
        .cz        (cen_z[k]),
        .ox        (ray_q[0].ox),
        .oy        (ray_q[0].oy),
        .oz        (ray_q[0].oz),
        .dx        (ray_q[0].dx),
        .dy        (ray_q[0].dy),
        .dz        (ray_q[0].dz),
        .radius_sq (radius_sq),
        .near_t    (lane_near[k]),
        .far_t     (lane_far[k]),
        .ok        (lane_ok[k])
      );
    end else begin : g_pad
      assign lane_near[k] = '0;
      assign lane_far[k] = '0;
      assign lane_ok[k] = 1'b0;
    end
  end

  // leaves pick the nearer valid root of each lane, then a registered tree walks
  // the slots in order; node_q[lvl] lines up with ray_q[LANE_LAT + 1 + lvl]
  cand_t node_q[TL+1][NL];
  cand_t leaf_near[NL];
  cand_t leaf_far[NL];
  logic signed [TW-1:0] md_s;

  assign md_s = $signed(TW'(min_dist));

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      leaf_near[k].v = lane_ok[k] && (k < int'(active)) && (lane_near[k] > md_s);
      leaf_near[k].idx = IW'(k);
      leaf_near[k].t = lane_near[k];
      leaf_far[k].v = lane_ok[k] && (k < int'(active)) && (lane_far[k] > md_s);
      leaf_far[k].idx = IW'(k);
      leaf_far[k].t = lane_far[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NL; k++) begin
        node_q[0][k] <= pick(leaf_near[k], leaf_far[k]);
      end
      for (int lvl = 1; lvl <= TL; lvl++) begin
        for (int j = 0; j < (NL >> lvl); j++) begin
          node_q[lvl][j] <= pick(node_q[lvl-1][2*j], node_q[lvl-1][2*j+1]);
        end
      end
    end
  end

  // hit point: multiply at MUL_STG, shift, add origin and saturate at the output
  cand_t              best_q;
  logic signed [51:0] mul_q[3];
  cand_t              best;
  ray_t               bray;

  assign best = node_q[TL][0];
  assign bray = ray_q[BS];

  always_ff @(posedge clk) begin
    if (en) begin
      best_q <= best;
      mul_q[0] <= 52'(bray.dx) * 52'(best.t);
      mul_q[1] <= 52'(bray.dy) * 52'(best.t);
      mul_q[2] <= 52'(bray.dz) * 52'(best.t);
    end
  end

  logic        hit_q;
  logic [2:0]  idx_q;
  logic [30:0] dist_q;
  logic signed [31:0] px_q;
  logic signed [31:0] py_q;
  logic signed [31:0] pz_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld_q[MS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (best_q.v) begin
        hit_q <= 1'b1;
        idx_q <= 3'(best_q.idx);
        dist_q <= (best_q.t > 34'sd2147483647) ? 31'h7fffffff : best_q.t[30:0];
        px_q <= rsch_pkg::sat32(64'(ray_q[MS].ox) + 64'(mul_q[0] >>> rsch_pkg::FRAC_BITS));
        py_q <= rsch_pkg::sat32(64'(ray_q[MS].oy) + 64'(mul_q[1] >>> rsch_pkg::FRAC_BITS));
        pz_q <= rsch_pkg::sat32(64'(ray_q[MS].oz) + 64'(mul_q[2] >>> rsch_pkg::FRAC_BITS));
      end else begin
        // no hit: every field is zero
        hit_q <= 1'b0;
        idx_q <= '0;
        dist_q <= '0;
        px_q <= '0;
        py_q <= '0;
        pz_q <= '0;
      end
    end
  end

  assign m_axis_tdata = {6'd0, pz_q, py_q, px_q, dist_q, idx_q};
  assign m_axis_tuser = hit_q;

endmodule

[design/rsch_checker.sv]
module rsch_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rsch_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);

  // hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  // stall the input while the output is stalled
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss with nonzero fields");

  // a hit lies strictly beyond a non-negative minimum distance
  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[33:3] != '0)
    else $error("hit with zero distance");

endmodule

bind ray_sphere_closest_hit rsch_checker u_rsch_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/testbench.sv]
module testbench;

  localparam bit          CMD_LOAD   = 1'b0;
  localparam bit          CMD_TRACE  = 1'b1;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam int          ONE        = 65536;      // 1.0 in Q16.16
  localparam logic [17:0] DIR_ONE    = 18'd65536;  // 1.0 as a direction component
  localparam longint      S32MAX     = 64'sd2147483647;
  localparam longint      S32MIN     = -64'sd2147483648;

  // Expected hit record for one trace item.
  typedef struct {
    bit        hit;
    bit [2:0]  idx;
    bit [30:0] distance;
    bit [31:0] px, py, pz;
  } hit_rec_t;

  // Own copy of the sphere table and the registers; predicts the nearest hit of
  // every accepted trace item and checks results in order.
  class hit_scoreboard;
    logic signed [31:0] ctr_x[8], ctr_y[8], ctr_z[8];
    longint unsigned    rad_sq;
    longint             min_dist;
    int unsigned        num_active;
    hit_rec_t           pending[$];
    int                 errors;

    function new();
      rad_sq     = 16384;
      min_dist   = 1;
      num_active = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        rsch_pkg::CFG_RADIUS_SQ: rad_sq     = 64'(val[30:0]);
        rsch_pkg::CFG_MIN_DIST:  min_dist   = 64'(val[15:0]);
        rsch_pkg::CFG_ACTIVE:    num_active = 32'(val[3:0]);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Accepted input item: load a center or predict a trace.
    function void note_item(bit cmd, logic [255:0] td);
      longint          o[3], d[3], c[3], l[3], dot, s, q, cand, best_t;
      longint unsigned lsq, s2, q2, m2, r2s;
      int              n, best_k;
      bit              found;
      hit_rec_t        rec;
      if (cmd == CMD_LOAD) begin
        ctr_x[td[2:0]] = td[34:3];
        ctr_y[td[2:0]] = td[66:35];
        ctr_z[td[2:0]] = td[98:67];
        return;
      end
      o[0] = longint'($signed(td[130:99]));
      o[1] = longint'($signed(td[162:131]));
      o[2] = longint'($signed(td[194:163]));
      d[0] = longint'($signed(td[212:195]));
      d[1] = longint'($signed(td[230:213]));
      d[2] = longint'($signed(td[248:231]));
      r2s = rad_sq << rsch_pkg::FRAC_BITS;
      n = num_active > 8 ? 8 : num_active;
      found = 0;
      best_t = 0;
      best_k = 0;
      for (int k = 0; k < n; k++) begin
        c[0] = ctr_x[k];
        c[1] = ctr_y[k];
        c[2] = ctr_z[k];
        dot = 0;
        lsq = 0;
        for (int i = 0; i < 3; i++) begin
          l[i] = clamp(c[i] - o[i], S32MIN, S32MAX);
          dot += l[i] * d[i];
          lsq += longint'(l[i] * l[i]);
        end
        s = clamp(dot >>> rsch_pkg::FRAC_BITS, -S32MAX, S32MAX);
        // behind the origin and origin outside: early miss
        if (s < 0 && lsq > r2s) continue;
        s2 = s * s;
        if (lsq >= s2) begin
          m2 = lsq - s2;
          if (m2 > r2s) continue;
          q2 = r2s - m2;
        end else begin
          q2 = r2s + (s2 - lsq);
        end
        q = longint'(root(q2));
        for (int j = 0; j < 2; j++) begin
          cand = j == 0 ? s - q : s + q;
          // strict compare keeps the earlier candidate on a tie
          if (cand > min_dist && (!found || cand < best_t)) begin
            found = 1;
            best_t = cand;
            best_k = k;
          end
        end
      end
      rec = '{0, 0, 0, 0, 0, 0};
      if (found) begin
        rec.hit      = 1;
        rec.idx      = best_k[2:0];
        rec.distance = 31'(clamp(best_t, 0, S32MAX));
        rec.px = 32'(clamp(o[0] + ((d[0] * best_t) >>> rsch_pkg::FRAC_BITS), S32MIN, S32MAX));
        rec.py = 32'(clamp(o[1] + ((d[1] * best_t) >>> rsch_pkg::FRAC_BITS), S32MIN, S32MAX));
        rec.pz = 32'(clamp(o[2] + ((d[2] * best_t) >>> rsch_pkg::FRAC_BITS), S32MIN, S32MAX));
      end
      pending = {pending, rec};
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bit hit, logic [135:0] td);
      hit_rec_t e;
      if (pending.size() == 0) begin
        report("result with no trace waiting");
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) report($sformatf("hit %0b, want %0b", hit, e.hit));
      if (td[2:0] !== e.idx) report($sformatf("index %0d, want %0d", td[2:0], e.idx));
      if (td[33:3] !== e.distance)
        report($sformatf("distance %0d, want %0d", td[33:3], e.distance));
      if (td[65:34] !== e.px) report($sformatf("point x %h, want %h", td[65:34], e.px));
      if (td[97:66] !== e.py) report($sformatf("point y %h, want %h", td[97:66], e.py));
      if (td[129:98] !== e.pz) report($sformatf("point z %h, want %h", td[129:98], e.pz));
    endtask
  endclass

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [255:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_valid, cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  hit_scoreboard sb = new();
  bit            tx_idle;   // sender gaps enabled
  bit            rx_idle;   // receiver stalls enabled
  bit            hold_rx;   // request one long receiver hold-off

  ray_sphere_closest_hit u_top (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Pack one input item; slot sits in the lowest bits.
  function logic [255:0] make_item(logic [2:0] slot, logic [31:0] cx, logic [31:0] cy,
                                   logic [31:0] cz, logic [31:0] ox, logic [31:0] oy,
                                   logic [31:0] oz, logic [17:0] dx, logic [17:0] dy,
                                   logic [17:0] dz);
    return {7'b0, dz, dy, dx, oz, oy, ox, cz, cy, cx, slot};
  endfunction

  // Offer one item after a random gap; note it once accepted.
  task send(bit cmd, logic [255:0] td);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= td;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(cmd, td);
  endtask

  // Drain the pipeline before touching a register.
  task settle();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function logic [31:0] near_coord(int units);
    return 32'($urandom_range(0, 2 * units * ONE) - units * ONE);
  endfunction

  function logic [17:0] rand_dir();
    if ($urandom_range(0, 19) == 0) return 18'($urandom);
    return 18'($urandom_range(0, 2 * ONE) - ONE);
  endfunction

  // Mostly well-formed traces against nearby spheres, some reloads, some noise.
  task random_item();
    int          r;
    logic [31:0] c[3], o[3];
    r = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      c[i] = r < 4 ? $urandom : near_coord(10);
      o[i] = r > 92 ? $urandom : near_coord(4);
    end
    if (r < 15)
      send(CMD_LOAD, make_item(3'($urandom), c[0], c[1], c[2], $urandom, $urandom,
                               $urandom, 18'($urandom), 18'($urandom), 18'($urandom)));
    else
      send(CMD_TRACE, make_item(3'($urandom), $urandom, $urandom, $urandom, o[0], o[1],
                                o[2], rand_dir(), rand_dir(), rand_dir()));
  endtask

  // Compare every result that leaves the block.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int w;
    m_axis_tready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk);
        hold_rx = 0;
      end
      w = rx_idle ? $urandom_range(0, 16) : 0;
      if (w > 0) begin
        m_axis_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] setting[5][3];
    tx_idle = 1;
    rx_idle = 1;
    hold_rx = 0;
    rst <= 1;
    s_axis_tvalid <= 0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_LOAD;
    cfg_valid <= 0;
    cfg_index <= rsch_pkg::CFG_RADIUS_SQ;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Load every slot before any trace can read it; slot 7 takes the extremes.
    send(CMD_LOAD, make_item(0, 5 * ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    send(CMD_LOAD, make_item(1, 5 * ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    send(CMD_LOAD, make_item(2, 0, 3 * ONE, 0, 0, 0, 0, 0, 0, 0));
    send(CMD_LOAD, make_item(3, 0, 0, -3 * ONE, 0, 0, 0, 0, 0, 0));
    send(CMD_LOAD, make_item(4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(CMD_LOAD, make_item(5, -2 * ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
    send(CMD_LOAD, make_item(6, 0, 0, 8 * ONE, 0, 0, 0, 0, 0, 0));
    send(CMD_LOAD, make_item(7, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                             0, 0, 0, 0, 0, 0));
    // reset settings: nothing active, so no hit
    send(CMD_TRACE, make_item(0, 0, 0, 0, 0, 0, 0, DIR_ONE, 0, 0));
    settle();

    write_reg(rsch_pkg::CFG_RADIUS_SQ, 4 * ONE);
    write_reg(rsch_pkg::CFG_MIN_DIST, 0);
    write_reg(rsch_pkg::CFG_ACTIVE, 8);
    write_reg(CFG_UNUSED, 32'hffffffff);
    // slots 0 and 1 are identical, but slot 4 around the origin gives the nearer hit
    send(CMD_TRACE, make_item(0, 0, 0, 0, 0, 0, 0, DIR_ONE, 0, 0));
    send(CMD_TRACE, make_item(0, 0, 0, 0, 0, 0, 0, 0, DIR_ONE, 0));
    send(CMD_TRACE, make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, -DIR_ONE));
    // origin inside the sphere at slot 4: only the far candidate counts
    send(CMD_TRACE, make_item(0, 0, 0, 0, ONE / 2, 0, 0, -DIR_ONE, 0, 0));
    // origin outside everything, ray pointing away from every slot but 7: no hit
    send(CMD_TRACE, make_item(0, 0, 0, 0, 20 * ONE, 20 * ONE, 20 * ONE,
                              DIR_ONE, DIR_ONE, DIR_ONE));
    // extreme origins and direction field extremes, saturated difference and point
    send(CMD_TRACE, make_item(0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000,
                              18'h1ffff, 18'h20000, 18'h1ffff));
    send(CMD_TRACE, make_item(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              18'h20000, 18'h1ffff, 18'h20000));
    send(CMD_TRACE, make_item(0, 0, 0, 0, 0, 0, 0, 18'h1ffff, 18'h1ffff, 18'h1ffff));
    send(CMD_TRACE, make_item(0, 0, 0, 0, -ONE, 0, 0, 0, 0, 0));
    settle();

    // radius, min distance, active count; extremes included, active above the table size
    setting[0] = '{9 * ONE, 1, 8};
    setting[1] = '{32'h7fffffff, 16'hffff, 15};
    setting[2] = '{2 * ONE, 0, 8};
    setting[3] = '{0, 0, 1};
    setting[4] = '{32'hffffffff, 16'h8000, 5};
    for (int p = 0; p < 5; p++) begin
      write_reg(rsch_pkg::CFG_RADIUS_SQ, setting[p][0]);
      write_reg(rsch_pkg::CFG_MIN_DIST, setting[p][1]);
      write_reg(rsch_pkg::CFG_ACTIVE, setting[p][2]);
      // phase 1 runs without any idling on either side
      tx_idle = p != 1;
      rx_idle = p != 1;
      for (int n = 0; n < 335; n++) begin
        // phase 2: hold off the receiver while the sender keeps going full rate
        if (p == 2 && n == 50) begin
          tx_idle = 0;
          hold_rx = 1;
        end
        if (p == 2 && n == 250) tx_idle = 1;
        random_item();
      end
      settle();
    end

    if (sb.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
